// ----- hdl/multi_level_priority_queue_defines.svh -----
// assertion macros for the priority queue
`ifndef MULTI_LEVEL_PRIORITY_QUEUE_DEFINES_SVH
`define MULTI_LEVEL_PRIORITY_QUEUE_DEFINES_SVH

`ifndef SYNTHESIS

`define MLPQ_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

`define MLPQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define MLPQ_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)

`define MLPQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

// ----- hdl/mlpq_pkg.sv -----
package mlpq_pkg;

	localparam logic OP_ENQUEUE = 1'b0;
	localparam logic OP_DEQUEUE = 1'b1;

	localparam logic [1:0] STATUS_OK        = 2'd0;
	localparam logic [1:0] STATUS_EMPTY     = 2'd1;
	localparam logic [1:0] STATUS_FULL      = 2'd2;
	localparam logic [1:0] STATUS_BAD_LEVEL = 2'd3;

	localparam int LEVEL_COUNT_RESET = 3;

endpackage

// ----- hdl/mlpq_store.sv -----
module mlpq_store #(
	parameter int DATA_W = 34,
	parameter int DEPTH  = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [DATA_W-1:0]        wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [DATA_W-1:0]        rdata
);

	logic [DATA_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- hdl/multi_level_priority_queue.sv -----
// Priority queue with per-level first-in first-out order, entries kept in arrival order
// in one single-port-read, single-port-write store. A beat is taken when start is high
// and busy is low; its result appears on value_out, status and entry_count with done
// high for exactly one cycle, and the receiver cannot stall it. Enqueues, rejected
// enqueues and dequeues on an empty queue never raise busy: their result comes the
// cycle after the beat and a new beat may follow at once. A successful dequeue raises
// busy until every entry stored behind the removed one has been read and written back
// one place lower through the store, one entry per cycle. Configuration writes are
// registered and should be made while idle.
`include "multi_level_priority_queue_defines.svh"

module multi_level_priority_queue
	import mlpq_pkg::*;
#(
	parameter int STORE_DEPTH = 16,
	parameter int MAX_LEVELS  = 4,
	parameter int VALUE_WIDTH = 32
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   start,
	output logic                                   busy,
	input  logic                                   opcode,
	input  logic signed [VALUE_WIDTH-1:0]          value,
	input  logic [$clog2(MAX_LEVELS)-1:0]          level,
	input  logic                                   cfg_wr_en,
	input  logic [$clog2(MAX_LEVELS+1)-1:0]        cfg_wr_data,
	output logic                                   done,
	output logic signed [VALUE_WIDTH-1:0]          value_out,
	output logic [1:0]                             status,
	output logic [$clog2(STORE_DEPTH+1)-1:0]       entry_count
);

	localparam int IDX_W  = $clog2(STORE_DEPTH);
	localparam int CNT_W  = $clog2(STORE_DEPTH + 1);
	localparam int LVL_W  = $clog2(MAX_LEVELS);
	localparam int CFG_W  = $clog2(MAX_LEVELS + 1);
	localparam int DATA_W = VALUE_WIDTH + LVL_W;

	localparam logic [CNT_W-1:0] HEAD_NONE = CNT_W'(STORE_DEPTH);

	localparam logic ST_IDLE  = 1'b0;
	localparam logic ST_SHIFT = 1'b1;

	logic                   state_q;
	logic [CNT_W-1:0]       count_q;
	logic [CNT_W-1:0]       head_q [MAX_LEVELS];
	logic [CFG_W-1:0]       level_count_q;
	logic                   done_q;
	logic                   pend_s1;
	logic                   first_s1;
	logic                   found_q;
	logic [CNT_W-1:0]       addr_s1;
	logic [CNT_W-1:0]       rd_ptr_q;
	logic [LVL_W-1:0]       tlvl_q;
	logic [VALUE_WIDTH-1:0] res_value_q;
	logic [1:0]             res_status_q;
	logic [CNT_W-1:0]       res_count_q;

	logic [CFG_W-1:0]       levels_eff;
	logic                   accept;
	logic                   level_bad;
	logic                   store_full;
	logic                   enq_ok;
	logic                   hit;
	logic [CNT_W-1:0]       target;
	logic [LVL_W-1:0]       target_lvl;
	logic                   deq_go;
	logic                   issue;
	logic                   shift_wr;
	logic                   shift_done;
	logic [CNT_W-1:0]       shift_waddr;
	logic [LVL_W-1:0]       rd_level;

	logic                   mem_we;
	logic [IDX_W-1:0]       mem_waddr;
	logic [DATA_W-1:0]      mem_wdata;
	logic                   mem_re;
	logic [IDX_W-1:0]       mem_raddr;
	logic [DATA_W-1:0]      mem_rdata;

	always_comb begin
		if (level_count_q == '0) begin
			levels_eff = CFG_W'(1);
		end else if (level_count_q > CFG_W'(MAX_LEVELS)) begin
			levels_eff = CFG_W'(MAX_LEVELS);
		end else begin
			levels_eff = level_count_q;
		end
	end

	// highest active level with an entry wins
	always_comb begin
		hit        = 1'b0;
		target     = HEAD_NONE;
		target_lvl = '0;
		for (int i = 0; i < MAX_LEVELS; i++) begin
			if (CFG_W'(i) < levels_eff && head_q[i] != HEAD_NONE && head_q[i] < count_q) begin
				hit        = 1'b1;
				target     = head_q[i];
				target_lvl = LVL_W'(i);
			end
		end
	end

	assign busy        = (state_q != ST_IDLE);
	assign accept      = start && !busy;
	assign level_bad   = CFG_W'(level) >= levels_eff;
	assign store_full  = count_q >= CNT_W'(STORE_DEPTH);
	assign enq_ok      = accept && opcode == OP_ENQUEUE && !level_bad && !store_full;
	assign deq_go      = accept && opcode == OP_DEQUEUE && hit;

	assign issue       = (state_q == ST_SHIFT) && rd_ptr_q <= count_q;
	assign shift_wr    = (state_q == ST_SHIFT) && pend_s1 && !first_s1;
	assign shift_done  = (state_q == ST_SHIFT) && !issue && !pend_s1;
	assign shift_waddr = addr_s1 - CNT_W'(1);
	assign rd_level    = mem_rdata[DATA_W-1:VALUE_WIDTH];

	assign mem_we    = enq_ok || shift_wr;
	assign mem_waddr = enq_ok ? count_q[IDX_W-1:0] : shift_waddr[IDX_W-1:0];
	assign mem_wdata = enq_ok ? {level, value} : mem_rdata;
	assign mem_re    = deq_go || issue;
	assign mem_raddr = deq_go ? target[IDX_W-1:0] : rd_ptr_q[IDX_W-1:0];

	mlpq_store #(
		.DATA_W(DATA_W),
		.DEPTH (STORE_DEPTH)
	) u_store (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.re   (mem_re),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			count_q       <= '0;
			level_count_q <= CFG_W'(LEVEL_COUNT_RESET);
			done_q        <= 1'b0;
			pend_s1       <= 1'b0;
			first_s1      <= 1'b0;
			found_q       <= 1'b0;
			for (int i = 0; i < MAX_LEVELS; i++) begin
				head_q[i] <= HEAD_NONE;
			end
		end else begin
			done_q <= (accept && !deq_go) || shift_done;
			if (cfg_wr_en) begin
				level_count_q <= cfg_wr_data;
			end
			if (enq_ok) begin
				count_q <= count_q + CNT_W'(1);
				if (head_q[level] == HEAD_NONE) begin
					head_q[level] <= count_q;
				end
			end
			if (deq_go) begin
				state_q  <= ST_SHIFT;
				count_q  <= count_q - CNT_W'(1);
				pend_s1  <= 1'b1;
				first_s1 <= 1'b1;
				found_q  <= 1'b0;
				for (int i = 0; i < MAX_LEVELS; i++) begin
					if (LVL_W'(i) == target_lvl) begin
						head_q[i] <= HEAD_NONE;
					end else if (head_q[i] != HEAD_NONE && head_q[i] > target) begin
						head_q[i] <= head_q[i] - CNT_W'(1);
					end
				end
			end else if (state_q == ST_SHIFT) begin
				pend_s1  <= issue;
				first_s1 <= 1'b0;
				// first later entry of the served level becomes its new head
				if (shift_wr && !found_q && rd_level == tlvl_q) begin
					found_q        <= 1'b1;
					head_q[tlvl_q] <= shift_waddr;
				end
				if (shift_done) begin
					state_q <= ST_IDLE;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (deq_go) begin
			rd_ptr_q <= target + CNT_W'(1);
			addr_s1  <= target;
			tlvl_q   <= target_lvl;
		end else if (issue) begin
			rd_ptr_q <= rd_ptr_q + CNT_W'(1);
			addr_s1  <= rd_ptr_q;
		end
		if (state_q == ST_SHIFT && pend_s1 && first_s1) begin
			res_value_q <= mem_rdata[VALUE_WIDTH-1:0];
		end
		if (accept && !deq_go) begin
			res_value_q <= '0;
			if (opcode == OP_DEQUEUE) begin
				res_status_q <= STATUS_EMPTY;
				res_count_q  <= count_q;
			end else if (level_bad) begin
				res_status_q <= STATUS_BAD_LEVEL;
				res_count_q  <= count_q;
			end else if (store_full) begin
				res_status_q <= STATUS_FULL;
				res_count_q  <= count_q;
			end else begin
				res_status_q <= STATUS_OK;
				res_count_q  <= count_q + CNT_W'(1);
			end
		end else if (shift_done) begin
			res_status_q <= STATUS_OK;
			res_count_q  <= count_q;
		end
	end

	assign done        = done_q;
	assign value_out   = res_value_q;
	assign status      = res_status_q;
	assign entry_count = res_count_q;

	`MLPQ_ASSERT_IMP(a_done_idle, clk, arst_n, done_q, state_q == ST_IDLE, "result while busy")
	`MLPQ_ASSERT_IMP(a_count_range, clk, arst_n, 1'b1, count_q <= CNT_W'(STORE_DEPTH), "count overflow")
	`MLPQ_ASSERT_IMP(a_no_rw_clash, clk, arst_n, mem_we && mem_re, mem_waddr != mem_raddr, "store read/write clash")
	`MLPQ_ASSERT_NEXT(a_enq_result, clk, arst_n, accept && opcode == OP_ENQUEUE, done_q, "enqueue result missing")
	`MLPQ_ASSERT_IMP(a_shift_quiet, clk, arst_n, state_q == ST_SHIFT, !enq_ok, "enqueue during shift")

endmodule

// ----- dv/mlpq_checker.sv -----
module mlpq_checker
	import mlpq_pkg::*;
#(
	parameter int STORE_DEPTH = 16,
	parameter int MAX_LEVELS  = 4,
	parameter int VALUE_WIDTH = 32
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	input  logic                                 busy,
	input  logic                                 opcode,
	input  logic signed [VALUE_WIDTH-1:0]        value,
	input  logic [$clog2(MAX_LEVELS)-1:0]        level,
	input  logic                                 cfg_wr_en,
	input  logic [$clog2(MAX_LEVELS+1)-1:0]      cfg_wr_data,
	input  logic                                 done,
	input  logic signed [VALUE_WIDTH-1:0]        value_out,
	input  logic [1:0]                           status,
	input  logic [$clog2(STORE_DEPTH+1)-1:0]     entry_count,
	output int                                   mismatch_count,
	output int                                   outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int LEVEL_W = $clog2(MAX_LEVELS);
	localparam int COUNT_W = $clog2(STORE_DEPTH + 1);
	localparam int SETTING_W = $clog2(MAX_LEVELS + 1);

	typedef struct {
		logic signed [VALUE_WIDTH-1:0] value;
		logic [LEVEL_W-1:0]            level;
	} entry_t;

	typedef struct {
		logic signed [VALUE_WIDTH-1:0] value_out;
		logic [1:0]                    status;
		logic [COUNT_W-1:0]            entry_count;
	} result_t;

	entry_t held_entries[$];
	result_t due_results[$];
	logic [SETTING_W-1:0] level_setting;
	int fails = 0;

	// applies one operation to the shadow queue, returns the result it should give
	function automatic result_t serve_op(input logic op, input logic signed [VALUE_WIDTH-1:0] v,
			input logic [LEVEL_W-1:0] lv);
		result_t r;
		entry_t e;
		int levels;
		int pick;
		levels = (level_setting == 0) ? 1 :
			(level_setting > MAX_LEVELS) ? MAX_LEVELS : int'(level_setting);
		r.value_out = '0;
		r.status = STATUS_OK;
		if (op == OP_ENQUEUE) begin
			if (lv >= levels) begin
				r.status = STATUS_BAD_LEVEL;
			end else if (held_entries.size() >= STORE_DEPTH) begin
				r.status = STATUS_FULL;
			end else begin
				e.value = v;
				e.level = lv;
				held_entries.push_back(e);
			end
		end else begin
			// oldest entry of the highest active level that has one
			pick = -1;
			for (int l = levels - 1; l >= 0; l--) begin
				if (pick < 0) begin
					foreach (held_entries[i])
						if (pick < 0 && held_entries[i].level == l)
							pick = i;
				end
			end
			if (pick < 0) begin
				r.status = STATUS_EMPTY;
			end else begin
				r.value_out = held_entries[pick].value;
				held_entries.delete(pick);
			end
		end
		r.entry_count = COUNT_W'(held_entries.size());
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		result_t want;
		if (!arst_n) begin
			held_entries.delete();
			due_results.delete();
			level_setting = SETTING_W'(LEVEL_COUNT_RESET);
			outstanding <= 0;
			mismatch_count <= fails;
		end else begin
			if (done) begin
				if (due_results.size() == 0) begin
					fails++;
					if (fails <= 10)
						$display("%t: result with none due: value_out %0d status %0d entry_count %0d",
							$realtime, value_out, status, entry_count);
				end else begin
					want = due_results.pop_front();
					if (value_out !== want.value_out || status !== want.status ||
							entry_count !== want.entry_count) begin
						fails++;
						if (fails <= 10)
							$display({"%t: mismatch: value_out %0d/%0d status %0d/%0d ",
								"entry_count %0d/%0d (expected/actual)"}, $realtime,
								want.value_out, value_out, want.status, status,
								want.entry_count, entry_count);
					end
				end
			end
			if (start && !busy)
				due_results.push_back(serve_op(opcode, value, level));
			if (cfg_wr_en)
				level_setting = cfg_wr_data;
			outstanding <= due_results.size();
			mismatch_count <= fails;
		end
	end

endmodule

// ----- dv/tb.sv -----
module tb;
	import mlpq_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int STORE_DEPTH = 16;
	localparam int MAX_LEVELS  = 4;
	localparam int VALUE_WIDTH = 32;
	localparam int QUIET_LIMIT = 2000;
	localparam int PHASE_BEATS = 180;
	localparam int SETTLE_CYCLES = 24;
	localparam int LEVEL_W = $clog2(MAX_LEVELS);
	localparam int SETTING_W = $clog2(MAX_LEVELS + 1);

	logic                                 clk;
	logic                                 arst_n;
	logic                                 start;
	logic                                 busy;
	logic                                 opcode;
	logic signed [VALUE_WIDTH-1:0]        value;
	logic [$clog2(MAX_LEVELS)-1:0]        level;
	logic                                 cfg_wr_en;
	logic [$clog2(MAX_LEVELS+1)-1:0]      cfg_wr_data;
	logic                                 done;
	logic signed [VALUE_WIDTH-1:0]        value_out;
	logic [1:0]                           status;
	logic [$clog2(STORE_DEPTH+1)-1:0]     entry_count;

	int mismatch_count;
	int outstanding;
	int idle_pct = 0;
	int quiet_cycles = 0;

	int level_plan[8] = '{4, 1, 0, 7, 2, 5, 3, 4};
	int idle_plan[3] = '{0, 68, 10};

	multi_level_priority_queue #(
		.STORE_DEPTH(STORE_DEPTH),
		.MAX_LEVELS (MAX_LEVELS),
		.VALUE_WIDTH(VALUE_WIDTH)
	) i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.opcode     (opcode),
		.value      (value),
		.level      (level),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.done       (done),
		.value_out  (value_out),
		.status     (status),
		.entry_count(entry_count)
	);

	mlpq_checker #(
		.STORE_DEPTH(STORE_DEPTH),
		.MAX_LEVELS (MAX_LEVELS),
		.VALUE_WIDTH(VALUE_WIDTH)
	) i_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.opcode        (opcode),
		.value         (value),
		.level         (level),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.done          (done),
		.value_out     (value_out),
		.status        (status),
		.entry_count   (entry_count),
		.mismatch_count(mismatch_count),
		.outstanding   (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// one beat; start stays high into the next beat unless a gap is drawn
	task automatic push_beat(input logic op, input logic signed [VALUE_WIDTH-1:0] v,
			input logic [$clog2(MAX_LEVELS)-1:0] lv);
		start <= 1'b1;
		opcode <= op;
		value <= v;
		level <= lv;
		do @(posedge clk); while (busy);
		if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			opcode <= 1'($urandom_range(1));
			value <= $urandom;
			level <= LEVEL_W'($urandom_range(3));
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
	endtask

	task automatic settle();
		start <= 1'b0;
		do @(posedge clk); while (outstanding != 0 || busy);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_level_count(input int n);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= SETTING_W'(n);
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	function automatic logic signed [VALUE_WIDTH-1:0] pick_value();
		case ($urandom_range(7))
			0: return {1'b1, {(VALUE_WIDTH-1){1'b0}}};
			1: return {1'b0, {(VALUE_WIDTH-1){1'b1}}};
			2: return '0;
			3: return '1;
			default: return $urandom;
		endcase
	endfunction

	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || done)
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("Verification failed");
				$finish;
			end
		end
	end

	initial begin
		int enq_pct;
		arst_n = 1'b0;
		start = 1'b0;
		opcode = OP_ENQUEUE;
		value = '0;
		level = '0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// directed: empty, bad level, fill with extremes, full, bad level beats full, then dequeues
		push_beat(OP_DEQUEUE, '1, 2'd3);
		push_beat(OP_ENQUEUE, 32'sd5, 2'd3);
		for (int i = 0; i < STORE_DEPTH; i++) begin
			case (i % 4)
				0: push_beat(OP_ENQUEUE, {1'b0, {(VALUE_WIDTH-1){1'b1}}}, LEVEL_W'(i % 3));
				1: push_beat(OP_ENQUEUE, {1'b1, {(VALUE_WIDTH-1){1'b0}}}, LEVEL_W'(i % 3));
				2: push_beat(OP_ENQUEUE, '0, LEVEL_W'(i % 3));
				default: push_beat(OP_ENQUEUE, '1, LEVEL_W'(i % 3));
			endcase
		end
		push_beat(OP_ENQUEUE, 32'sd7, 2'd0);
		push_beat(OP_ENQUEUE, 32'sd9, 2'd3);
		repeat (4) push_beat(OP_DEQUEUE, $urandom, LEVEL_W'($urandom_range(3)));
		settle();

		foreach (level_plan[p]) begin
			write_level_count(level_plan[p]);
			idle_pct = idle_plan[p % 3];
			enq_pct = 50;
			for (int n = 0; n < PHASE_BEATS; n++) begin
				if (n % 40 == 0)
					enq_pct = $urandom_range(25, 80);
				if ($urandom_range(99) < enq_pct)
					push_beat(OP_ENQUEUE, pick_value(), LEVEL_W'($urandom_range(3)));
				else
					push_beat(OP_DEQUEUE, $urandom, LEVEL_W'($urandom_range(3)));
			end
			settle();
		end

		if (mismatch_count == 0 && outstanding == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

// ----- sim.f -----
+incdir+hdl
hdl/mlpq_pkg.sv
hdl/mlpq_store.sv
hdl/multi_level_priority_queue.sv
dv/mlpq_checker.sv
dv/tb.sv
